@@ hw/rtl/sstf_pkg.sv @@
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int SECTOR_W = 48;
    localparam int TAG_W    = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SECTOR_W-1:0] req_sector;
        logic [TAG_W-1:0]    req_tag;
    } sstf_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] out_sector;
        logic [TAG_W-1:0]    out_tag;
    } sstf_result_t;

    typedef struct packed {
        logic                load;
        logic                append;
        logic                scan_start;
        logic                shift_start;
        logic                drop;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } sstf_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            scan_done;
        logic            shift_done;
        logic            found;
    } sstf_status_t;

endpackage

@@ hw/rtl/sstf_ram.sv @@
`timescale 1ns / 1ps

module sstf_ram
#(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sstf_ctrl.sv @@
`timescale 1ns / 1ps

module sstf_ctrl
    import sstf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] start_op,
    input  sstf_status_t    sts,
    output sstf_cmd_t       cmd,
    output logic            busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (start_op)
                        OP_ADD:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_ADD;
                        end
                        OP_DISPATCH, OP_REMOVE:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.emit = 1'b1;
                if (sts.full)
                begin
                    cmd.emit_status = ST_FULL;
                end
                else
                begin
                    cmd.append      = 1'b1;
                    cmd.emit_status = ST_ADDED;
                end
                state_next = S_IDLE;
            end
            S_CHECK:
            begin
                if (sts.empty)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = (sts.op == OP_DISPATCH) ? ST_EMPTY : ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (!sts.found)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NOT_FOUND;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    cmd.drop        = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = (sts.op == OP_DISPATCH) ? ST_DISPATCHED : ST_REMOVED;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_scan_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> !sts.empty)
        else $error("scan started on an empty queue");

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after a result");

endmodule

@@ hw/rtl/sstf_datapath.sv @@
`timescale 1ns / 1ps

module sstf_datapath
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TAG_BITS    = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  sstf_item_t   item,
    input  sstf_cmd_t    cmd,
    output sstf_status_t sts,
    output logic         done,
    output sstf_result_t result
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TW     = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;
    localparam int ENTRY_W = SECTOR_W + TAG_BITS;

    logic [OP_W-1:0]     op_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TW-1:0]       in_tag_wide;

    logic [CNT_W-1:0]    count_reg;
    logic [SECTOR_W-1:0] head_reg;

    logic                scan_active_reg;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                v1_reg;
    logic [IDX_W-1:0]    idx1_reg;
    logic                v2_reg;
    logic [IDX_W-1:0]    idx2_reg;
    logic [SECTOR_W-1:0] dist_reg;
    logic [SECTOR_W-1:0] sec2_reg;
    logic [TAG_BITS-1:0] tag2_reg;

    logic                found_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic [SECTOR_W-1:0] best_dist_reg;
    logic [SECTOR_W-1:0] best_sec_reg;
    logic [TAG_BITS-1:0] best_tag_reg;

    logic                sh_active_reg;
    logic [CNT_W-1:0]    sh_rd_reg;
    logic                sh_v_reg;
    logic [IDX_W-1:0]    sh_wa_reg;
    logic [CNT_W-1:0]    pick_next_pos;

    logic                done_reg;
    sstf_result_t        result_reg;
    logic [TW-1:0]       out_tag_wide;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [SECTOR_W-1:0] rd_sec;
    logic [TAG_BITS-1:0] rd_tag;
    logic [SECTOR_W-1:0] rd_dist;

    assign in_tag_wide   = TW'(item.req_tag);
    assign rd_sec        = ram_rdata[TAG_BITS +: SECTOR_W];
    assign rd_tag        = ram_rdata[TAG_BITS-1:0];
    assign rd_dist       = (rd_sec >= head_reg) ? (rd_sec - head_reg) : (head_reg - rd_sec);
    assign pick_next_pos = CNT_W'(pick_reg) + CNT_W'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sh_wa_reg;
        ram_wdata = ram_rdata;
        if (cmd.append)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {sector_reg, tag_reg};
        end
        else if (sh_v_reg)
        begin
            ram_we = 1'b1;
        end
        ram_raddr = scan_active_reg ? scan_idx_reg[IDX_W-1:0] : sh_rd_reg[IDX_W-1:0];
    end

    sstf_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= item.op;
            sector_reg <= item.req_sector;
            tag_reg    <= in_tag_wide[TAG_BITS-1:0];
        end
        idx1_reg <= scan_idx_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        dist_reg <= rd_dist;
        sec2_reg <= rd_sec;
        tag2_reg <= rd_tag;
        sh_wa_reg <= sh_rd_reg[IDX_W-1:0] - IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            head_reg        <= '0;
            scan_active_reg <= 1'b0;
            scan_idx_reg    <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            found_reg       <= 1'b0;
            pick_reg        <= '0;
            best_dist_reg   <= '0;
            best_sec_reg    <= '0;
            best_tag_reg    <= '0;
            sh_active_reg   <= 1'b0;
            sh_rd_reg       <= '0;
            sh_v_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            v1_reg   <= scan_active_reg;
            v2_reg   <= v1_reg;
            sh_v_reg <= sh_active_reg;
            done_reg <= cmd.emit;

            if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.drop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.scan_start)
            begin
                scan_active_reg <= 1'b1;
                scan_idx_reg    <= '0;
                found_reg       <= 1'b0;
            end
            else if (scan_active_reg)
            begin
                scan_idx_reg    <= scan_idx_reg + CNT_W'(1);
                scan_active_reg <= (scan_idx_reg + CNT_W'(1)) < count_reg;
            end

            if (op_reg == OP_REMOVE)
            begin
                if (v1_reg && !found_reg && (rd_tag == tag_reg))
                begin
                    found_reg <= 1'b1;
                    pick_reg  <= idx1_reg;
                end
            end
            else if (v2_reg && (!found_reg || (dist_reg < best_dist_reg)))
            begin
                found_reg     <= 1'b1;
                pick_reg      <= idx2_reg;
                best_dist_reg <= dist_reg;
                best_sec_reg  <= sec2_reg;
                best_tag_reg  <= tag2_reg;
            end

            if (cmd.shift_start)
            begin
                sh_rd_reg     <= pick_next_pos;
                sh_active_reg <= pick_next_pos < count_reg;
                if (op_reg == OP_DISPATCH)
                begin
                    head_reg <= best_sec_reg;
                end
            end
            else if (sh_active_reg)
            begin
                sh_rd_reg     <= sh_rd_reg + CNT_W'(1);
                sh_active_reg <= (sh_rd_reg + CNT_W'(1)) < count_reg;
            end
        end
    end

    assign out_tag_wide = (cmd.emit_status == ST_DISPATCHED) ? TW'(best_tag_reg) :
                          (cmd.emit_status == ST_REMOVED)    ? TW'(tag_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.status     <= cmd.emit_status;
            result_reg.out_sector <= (cmd.emit_status == ST_DISPATCHED) ? best_sec_reg : '0;
            result_reg.out_tag    <= out_tag_wide[TAG_W-1:0];
        end
    end

    assign sts.op         = op_reg;
    assign sts.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.scan_done  = !scan_active_reg && !v1_reg && !v2_reg;
    assign sts.shift_done = !sh_active_reg && !sh_v_reg;
    assign sts.found      = found_reg;

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");

    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("append on a full queue");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !sh_v_reg)
        else $error("append collides with a shift write");

endmodule

@@ hw/rtl/shortest_seek_first_scheduler_top.sv @@
`timescale 1ns / 1ps

// Shortest-seek-first disk request scheduler.
// A transaction is taken on a rising edge where start is high and busy is low; the
// item carries an operation (add, dispatch nearest, remove by tag), a sector and a tag.
// The unused operation code is taken and ignored, with no result.
// Each other transaction gives exactly one result, shown on result for a single cycle
// with done high; the receiver cannot stall it and must take it in that cycle.
// Pending requests live in a single-port-write, registered-read RAM in arrival order.
// An add appends the item unless the queue is full. A dispatch scans every pending entry
// through a three-stage read, distance and compare pipeline, then shifts later entries
// forward one place per cycle; a remove does the same with a tag match. An empty or
// not-found case ends after the check or the scan.
// busy falls in the cycle that done is high, so the next transaction may start then.
// Reset empties the queue and puts the head at sector 0; the RAM needs no clearing.

module shortest_seek_first_scheduler_top
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TAG_BITS    = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  sstf_item_t   item,
    output logic         done,
    output sstf_result_t result
);

    sstf_cmd_t    cmd;
    sstf_status_t sts;

    sstf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_op (item.op),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    sstf_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule
